// ----- rtl/multiword_integer_alu_128_top_assert.svh -----
// Assertion macros for the 128-bit multiword ALU.
// Included by multiword_integer_alu_128_top; no other dependencies.
`ifndef MULTIWORD_INTEGER_ALU_128_TOP_ASSERT_SVH
`define MULTIWORD_INTEGER_ALU_128_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MIA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mia128_pkg.sv -----
// Package for the 128-bit multiword ALU: operation and order codes,
// pipeline sizing, stage payload type and the divider step. No dependencies.
package mia128_pkg;

    localparam int WORD_W        = 128;
    localparam int HALF_W        = 64;
    localparam int DVSR_W        = 16;
    // quotient bits resolved per pipeline stage
    localparam int DIV_STEP_BITS = 8;
    localparam int NUM_DIV_STAGES = WORD_W / DIV_STEP_BITS;
    // entry stage plus divider stages
    localparam int NUM_STAGES    = NUM_DIV_STAGES + 1;

    localparam int S_DATA_W = ((4 * HALF_W + DVSR_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * HALF_W + 7) / 8) * 8;
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_CMP = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ORD_GT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_LT = 2'd2
    } t_order;

    typedef struct packed {
        logic [WORD_W-1:0] work;
        logic [DVSR_W-1:0] rem;
    } t_div_state;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] work;
        logic [DVSR_W-1:0] rem;
        logic [DVSR_W-1:0] dvsr;
        t_order            order;
        logic              fault;
    } t_stage;

    // Restoring division over DIV_STEP_BITS bits: the dividend shifts out of
    // the top of work, quotient bits shift in at the bottom.
    function automatic t_div_state div_step(input t_div_state st,
                                            input logic [DVSR_W-1:0] d);
        t_div_state     s;
        logic [DVSR_W:0] trial;
        logic           q;
        s = st;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial = {s.rem, s.work[WORD_W-1]};
            if (trial >= {1'b0, d}) begin
                trial = trial - {1'b0, d};
                q     = 1'b1;
            end else begin
                q     = 1'b0;
            end
            // remainder stays below the divisor, so it fits
            s.rem  = trial[DVSR_W-1:0];
            s.work = {s.work[WORD_W-2:0], q};
        end
        return s;
    endfunction

endpackage

// ----- rtl/multiword_integer_alu_128_top.sv -----
// Top level of the 128-bit multiword ALU: add, subtract, compare and
// divide by a 16-bit divisor. Depends on mia128_pkg and the assertion header.
//
// Usage:
//  Slave channel i_s_axis_*: one word per operation, op in tuser, operands and
//  divisor in tdata. Master channel o_m_axis_*: one word per operation, the
//  128-bit sum, difference or quotient in tdata, compare order and the
//  zero-divisor flag in tuser.
//  Every operation passes through one entry stage (wide add, subtract and
//  compare) and sixteen divider stages of 8 quotient bits each. Throughput is
//  one word per cycle while the receiver does not stall; the divider's eight
//  17-bit trial subtractions per stage set the depth.
//  Reset clears every stage valid bit; payload registers are not reset.
//  When the receiver stalls, each full stage holds its word; empty stages
//  ahead of a stall still fill, so the block keeps accepting until all
//  seventeen stages hold a word.
`include "multiword_integer_alu_128_top_assert.svh"

module multiword_integer_alu_128_top
    import mia128_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // a_high, a_low, b_high, b_low, divisor
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // op
    input  logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // result_high, result_low
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // order_code, divide_fault
    output logic [M_USER_W-1:0] o_m_axis_tuser
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_valid;
    t_stage                r_stage [NUM_STAGES];
    t_stage                n_stage [NUM_STAGES];
    logic [NUM_STAGES-1:0] w_ready;

    logic [WORD_W-1:0] w_a;
    logic [WORD_W-1:0] w_b;
    logic [DVSR_W-1:0] w_dvsr;
    t_op               w_op;

    assign w_a    = {i_s_axis_tdata[HALF_W-1:0], i_s_axis_tdata[2*HALF_W-1:HALF_W]};
    assign w_b    = {i_s_axis_tdata[3*HALF_W-1:2*HALF_W],
                     i_s_axis_tdata[4*HALF_W-1:3*HALF_W]};
    assign w_dvsr = i_s_axis_tdata[4*HALF_W+DVSR_W-1:4*HALF_W];
    assign w_op   = t_op'(i_s_axis_tuser[1:0]);

    // stage ready chain: a stage moves on when empty or when the next one moves
    assign w_ready[LAST] = !r_valid[LAST] || i_m_axis_tready;
    for (genvar g = 0; g < LAST; g++) begin : g_ready
        assign w_ready[g] = !r_valid[g] || w_ready[g+1];
    end

    assign o_s_axis_tready = w_ready[0];

    // entry stage: wide add, subtract and compare; divide loads the dividend or flags a zero divisor
    always_comb begin
        n_stage[0].op    = w_op;
        n_stage[0].work  = '0;
        n_stage[0].rem   = '0;
        n_stage[0].dvsr  = w_dvsr;
        n_stage[0].order = ORD_GT;
        n_stage[0].fault = 1'b0;
        case (w_op)
            OP_ADD: begin
                n_stage[0].work = w_a + w_b;
            end
            OP_SUB: begin
                n_stage[0].work = w_a - w_b;
            end
            OP_CMP: begin
                if (w_a > w_b) begin
                    n_stage[0].order = ORD_GT;
                end else if (w_a == w_b) begin
                    n_stage[0].order = ORD_EQ;
                end else begin
                    n_stage[0].order = ORD_LT;
                end
            end
            OP_DIV: begin
                if (w_dvsr == '0) begin
                    n_stage[0].fault = 1'b1;
                end else begin
                    n_stage[0].work = w_a;
                end
            end
            default: begin
                n_stage[0].work = '0;
            end
        endcase
    end

    // divider stages: 8 quotient bits each, other words and faulted divides pass unchanged
    for (genvar g = 1; g < NUM_STAGES; g++) begin : g_div
        t_div_state w_cur;
        t_div_state w_nxt;
        assign w_cur.work = r_stage[g-1].work;
        assign w_cur.rem  = r_stage[g-1].rem;
        assign w_nxt      = div_step(w_cur, r_stage[g-1].dvsr);
        always_comb begin
            n_stage[g] = r_stage[g-1];
            if (r_stage[g-1].op == OP_DIV && !r_stage[g-1].fault) begin
                n_stage[g].work = w_nxt.work;
                n_stage[g].rem  = w_nxt.rem;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_STAGES; s++) begin
            if (w_ready[s]) begin
                r_stage[s] <= n_stage[s];
            end
        end
    end

    // output word
    assign o_m_axis_tvalid = r_valid[LAST];
    assign o_m_axis_tdata  = {r_stage[LAST].work[HALF_W-1:0],
                              r_stage[LAST].work[WORD_W-1:HALF_W]};
    assign o_m_axis_tuser  = {r_stage[LAST].fault, r_stage[LAST].order};

    // checks
    `MIA_ASSERT_SAME(a_fault_only_div, i_clk, i_rst_n,
        o_m_axis_tvalid && r_stage[LAST].fault,
        r_stage[LAST].op == OP_DIV && o_m_axis_tdata == '0)
    `MIA_ASSERT_SAME(a_order_only_cmp, i_clk, i_rst_n,
        o_m_axis_tvalid && r_stage[LAST].op != OP_CMP,
        r_stage[LAST].order == ORD_GT)
    `MIA_ASSERT_NEXT(a_accept_fills_entry, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready,
        r_valid[0])

endmodule
